// File: sv/ema_weight_averager_defines.svh
// Assertion macros used by the averager's back part (emawa_back).
// Each macro samples on the rising edge of clock and is muted while reset is high.
`ifndef EMA_WEIGHT_AVERAGER_DEFINES_SVH
`define EMA_WEIGHT_AVERAGER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EMAWA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EMAWA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/emawa_pkg.sv
`default_nettype none

package emawa_pkg;

   // Store geometry and the width of a stored average.
   localparam int WEIGHT_DEPTH = 1024;
   localparam int BIAS_DEPTH   = 256;
   localparam int VALUE_WIDTH  = 32;

   // The clearing pass runs over the deeper of the two stores.
   localparam int SWEEP_DEPTH = (WEIGHT_DEPTH > BIAS_DEPTH) ? WEIGHT_DEPTH : BIAS_DEPTH;
   localparam int WIDX_W  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
   localparam int BIDX_W  = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
   localparam int SWEEP_W = (SWEEP_DEPTH > 1) ? $clog2(SWEEP_DEPTH) : 1;

   // Fixed field widths of the ports.
   localparam int MODE_W      = 2;
   localparam int INDEX_W     = 10;
   localparam int FIELD_W     = 32;
   localparam int DECAY_W     = 16;
   localparam int WCOUNT_W    = 11;
   localparam int BCOUNT_W    = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Register reset values.
   localparam logic [DECAY_W-1:0]  DECAY_RESET  = 16'd65470;
   localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 11'd1024;
   localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 9'd256;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WCOUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BCOUNT = 2'd2;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   // Region codes.
   localparam logic REGION_WEIGHT = 1'b0;
   localparam logic REGION_BIAS   = 1'b1;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Mixing arithmetic: a signed average times an 18-bit signed weight, two such summed.
   localparam int PROD_W     = VALUE_WIDTH + DECAY_W + 2;
   localparam int SUM_W      = PROD_W + 1;
   localparam int ROUND_HALF = 1 << (DECAY_W - 1);
   localparam int DECAY_ONE  = 1 << DECAY_W;

   typedef enum logic [1:0] {
      OP_UPDATE,
      OP_READ,
      OP_CLEAR,
      OP_NONE
   } op_type;

   // One classified word as it travels through the queue.
   typedef struct packed {
      op_type                         kind;
      logic                           in_range;
      logic                           region;
      logic [INDEX_W-1:0]             index;
      logic signed [VALUE_WIDTH-1:0]  value;
      logic                           last;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   // One store entry: the written bit travels with the average.
   typedef struct packed {
      logic                           written;
      logic signed [VALUE_WIDTH-1:0]  avg;
   } entry_type;

   typedef enum logic [1:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_LOOKUP,
      BK_MIX
   } back_state_type;

endpackage

`default_nettype wire

// File: sv/emawa_front.sv
`default_nettype none

module emawa_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [emawa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [emawa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [emawa_pkg::MODE_W-1:0]        req_mode,
   input  wire logic                                req_region,
   input  wire logic [emawa_pkg::INDEX_W-1:0]       req_index,
   input  wire logic signed [emawa_pkg::FIELD_W-1:0] req_value,
   input  wire logic                                req_last,
   output emawa_pkg::item_type                      item_o,
   output logic [emawa_pkg::DECAY_W-1:0]            decay_o
);

   logic [emawa_pkg::DECAY_W-1:0]  decay_ff, decay_in;
   logic [emawa_pkg::WCOUNT_W-1:0] wcount_ff, wcount_in;
   logic [emawa_pkg::BCOUNT_W-1:0] bcount_ff, bcount_in;
   logic                           weight_ok;
   logic                           bias_ok;

   // Configuration register writes; unknown indexes are dropped.
   always_comb begin
      decay_in  = decay_ff;
      wcount_in = wcount_ff;
      bcount_in = bcount_ff;
      if (csr_we) begin
         case (csr_index)
            emawa_pkg::CSR_DECAY: begin
               decay_in = csr_wdata[emawa_pkg::DECAY_W-1:0];
            end
            emawa_pkg::CSR_WCOUNT: begin
               wcount_in = csr_wdata[emawa_pkg::WCOUNT_W-1:0];
            end
            emawa_pkg::CSR_BCOUNT: begin
               bcount_in = csr_wdata[emawa_pkg::BCOUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= emawa_pkg::DECAY_RESET;
         wcount_ff <= emawa_pkg::WCOUNT_RESET;
         bcount_ff <= emawa_pkg::BCOUNT_RESET;
      end else begin
         decay_ff  <= decay_in;
         wcount_ff <= wcount_in;
         bcount_ff <= bcount_in;
      end
   end

   // An index must sit below both the count in use and the store depth.
   assign weight_ok = ({1'b0, req_index} < wcount_ff)
                      && (int'(req_index) < emawa_pkg::WEIGHT_DEPTH);
   assign bias_ok   = (req_index < emawa_pkg::INDEX_W'(bcount_ff))
                      && (int'(req_index) < emawa_pkg::BIAS_DEPTH);

   // Classify the incoming word for the back part.
   always_comb begin
      case (req_mode)
         emawa_pkg::MODE_UPDATE: begin
            item_o.kind = emawa_pkg::OP_UPDATE;
         end
         emawa_pkg::MODE_READ: begin
            item_o.kind = emawa_pkg::OP_READ;
         end
         emawa_pkg::MODE_CLEAR: begin
            item_o.kind = emawa_pkg::OP_CLEAR;
         end
         default: begin
            item_o.kind = emawa_pkg::OP_NONE;
         end
      endcase
      item_o.in_range = (req_region == emawa_pkg::REGION_BIAS) ? bias_ok : weight_ok;
      item_o.region   = req_region;
      item_o.index    = req_index;
      item_o.value    = emawa_pkg::VALUE_WIDTH'(req_value);
      item_o.last     = req_last;
   end

   assign decay_o = decay_ff;

endmodule

`default_nettype wire

// File: sv/emawa_queue.sv
`default_nettype none

module emawa_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_i,
   input  wire emawa_pkg::item_type  item_i,
   input  wire logic                 pop_i,
   output emawa_pkg::q_head_type     head_o,
   output logic                      full_o
);

   emawa_pkg::item_type               entries_ff [emawa_pkg::QUEUE_DEPTH];
   logic [emawa_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [emawa_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [emawa_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full_o  = (count_ff == emawa_pkg::QCNT_W'(emawa_pkg::QUEUE_DEPTH));
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && (count_ff != '0);

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == emawa_pkg::QPTR_W'(emawa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == emawa_pkg::QPTR_W'(emawa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= item_i;
      end
   end

   assign head_o.valid = (count_ff != '0);
   assign head_o.item  = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: sv/emawa_back.sv
`default_nettype none
`include "ema_weight_averager_defines.svh"

module emawa_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire emawa_pkg::q_head_type                head_i,
   input  wire logic [emawa_pkg::DECAY_W-1:0]        decay_i,
   output logic                                      pop_o,
   output logic                                      sweeping_o,
   input  wire logic                                 rsp_ready_i,
   output logic                                      rsp_valid_o,
   output logic signed [emawa_pkg::FIELD_W-1:0]      rsp_average_o,
   output logic                                      rsp_flag_o
);

   // Stores: the written bit sits beside each average.
   emawa_pkg::entry_type weight_ram [emawa_pkg::WEIGHT_DEPTH];
   emawa_pkg::entry_type bias_ram   [emawa_pkg::BIAS_DEPTH];

   emawa_pkg::back_state_type         state_ff, state_in;
   logic [emawa_pkg::SWEEP_W-1:0]     cnt_ff, cnt_in;
   logic                              init_ff, init_in;
   emawa_pkg::item_type               item_ff, item_in;
   emawa_pkg::entry_type              weight_rd_ff;
   emawa_pkg::entry_type              bias_rd_ff;
   logic signed [emawa_pkg::PROD_W-1:0] prod_a_ff, prod_a_in;
   logic signed [emawa_pkg::PROD_W-1:0] prod_v_ff, prod_v_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [emawa_pkg::FIELD_W-1:0] rsp_average_ff, rsp_average_in;
   logic                              rsp_flag_ff, rsp_flag_in;

   logic [emawa_pkg::INDEX_W-1:0]     rd_index;
   logic                              w_we;
   logic                              b_we;
   logic [emawa_pkg::WIDX_W-1:0]      w_waddr;
   logic [emawa_pkg::BIDX_W-1:0]      b_waddr;
   emawa_pkg::entry_type              wr_entry;
   emawa_pkg::entry_type              sel_entry;
   logic signed [emawa_pkg::VALUE_WIDTH-1:0] cur_avg;
   logic signed [emawa_pkg::DECAY_W+1:0] d_coef;
   logic signed [emawa_pkg::DECAY_W+1:0] e_coef;
   logic signed [emawa_pkg::SUM_W-1:0] mix_sum;
   logic signed [emawa_pkg::VALUE_WIDTH-1:0] mix_avg;
   logic                              sweep_done;
   logic                              rsp_free;

   // Memory read address: the queue head while idle, else the word in work.
   assign rd_index = (state_ff == emawa_pkg::BK_IDLE) ? head_i.item.index : item_ff.index;

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_ram[w_waddr] <= wr_entry;
      end
      weight_rd_ff <= weight_ram[emawa_pkg::WIDX_W'(rd_index)];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bias_ram[b_waddr] <= wr_entry;
      end
      bias_rd_ff <= bias_ram[emawa_pkg::BIDX_W'(rd_index)];
   end

   // Current average of the selected entry; an unwritten entry counts as zero.
   assign sel_entry = (item_ff.region == emawa_pkg::REGION_BIAS) ? bias_rd_ff : weight_rd_ff;
   assign cur_avg   = sel_entry.written ? sel_entry.avg : '0;

   // Mix weights d (Q0.16) and (1 - d), both as 18-bit signed Q1.16 numbers.
   assign d_coef = $signed({2'b00, decay_i});
   assign e_coef = $signed((emawa_pkg::DECAY_W + 2)'(emawa_pkg::DECAY_ONE) - {2'b00, decay_i});

   // Operands widen to the product width with their signs before the multiply.
   assign prod_a_in = cur_avg * d_coef;
   assign prod_v_in = item_ff.value * e_coef;

   always_ff @(posedge clock) begin
      if (state_ff == emawa_pkg::BK_LOOKUP) begin
         prod_a_ff <= prod_a_in;
         prod_v_ff <= prod_v_in;
      end
   end

   // Round half up, then drop the fraction bits of the weights.
   assign mix_sum = emawa_pkg::SUM_W'(prod_a_ff) + emawa_pkg::SUM_W'(prod_v_ff)
                    + emawa_pkg::SUM_W'(emawa_pkg::ROUND_HALF);
   assign mix_avg = mix_sum[emawa_pkg::VALUE_WIDTH+emawa_pkg::DECAY_W-1:emawa_pkg::DECAY_W];

   assign sweep_done = (cnt_ff == emawa_pkg::SWEEP_W'(emawa_pkg::SWEEP_DEPTH - 1));
   assign rsp_free   = !rsp_valid_ff || rsp_ready_i;

   // Sequencer: clearing sweep, word fetch, lookup and mix.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      init_in        = init_ff;
      item_in        = item_ff;
      pop_o          = 1'b0;
      w_we           = 1'b0;
      b_we           = 1'b0;
      w_waddr        = emawa_pkg::WIDX_W'(item_ff.index);
      b_waddr        = emawa_pkg::BIDX_W'(item_ff.index);
      wr_entry       = '{written: 1'b1, avg: item_ff.value};
      rsp_valid_in   = rsp_valid_ff && !rsp_ready_i;
      rsp_average_in = rsp_average_ff;
      rsp_flag_in    = rsp_flag_ff;
      case (state_ff)
         emawa_pkg::BK_SWEEP: begin
            // One entry of each store per cycle goes back to unwritten zero, while the count is below its depth.
            wr_entry = '{written: 1'b0, avg: '0};
            w_waddr  = emawa_pkg::WIDX_W'(cnt_ff);
            b_waddr  = emawa_pkg::BIDX_W'(cnt_ff);
            w_we     = ({1'b0, cnt_ff} < (emawa_pkg::SWEEP_W + 1)'(emawa_pkg::WEIGHT_DEPTH));
            b_we     = ({1'b0, cnt_ff} < (emawa_pkg::SWEEP_W + 1)'(emawa_pkg::BIAS_DEPTH));
            cnt_in   = cnt_ff + 1'b1;
            if (sweep_done) begin
               cnt_in   = '0;
               state_in = emawa_pkg::BK_IDLE;
            end
         end
         emawa_pkg::BK_IDLE: begin
            if (head_i.valid) begin
               pop_o   = 1'b1;
               item_in = head_i.item;
               case (head_i.item.kind)
                  emawa_pkg::OP_CLEAR: begin
                     init_in  = 1'b0;
                     cnt_in   = '0;
                     state_in = emawa_pkg::BK_SWEEP;
                  end
                  emawa_pkg::OP_UPDATE: begin
                     if (head_i.item.in_range) begin
                        state_in = emawa_pkg::BK_LOOKUP;
                     end else if (head_i.item.last) begin
                        // An ignored element still closes the pass.
                        init_in = 1'b1;
                     end
                  end
                  emawa_pkg::OP_READ: begin
                     state_in = emawa_pkg::BK_LOOKUP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         emawa_pkg::BK_LOOKUP: begin
            if (item_ff.kind == emawa_pkg::OP_READ) begin
               // The read waits here until the response register is free.
               if (rsp_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_flag_in    = item_ff.in_range && init_ff;
                  rsp_average_in = (item_ff.in_range && init_ff)
                                   ? emawa_pkg::FIELD_W'(cur_avg) : '0;
                  state_in       = emawa_pkg::BK_IDLE;
               end
            end else if (!init_ff) begin
               // First pass: the element is copied as it is.
               w_we     = (item_ff.region == emawa_pkg::REGION_WEIGHT);
               b_we     = (item_ff.region == emawa_pkg::REGION_BIAS);
               init_in  = init_ff || item_ff.last;
               state_in = emawa_pkg::BK_IDLE;
            end else begin
               state_in = emawa_pkg::BK_MIX;
            end
         end
         emawa_pkg::BK_MIX: begin
            wr_entry = '{written: 1'b1, avg: mix_avg};
            w_we     = (item_ff.region == emawa_pkg::REGION_WEIGHT);
            b_we     = (item_ff.region == emawa_pkg::REGION_BIAS);
            init_in  = init_ff || item_ff.last;
            state_in = emawa_pkg::BK_IDLE;
         end
         default: begin
            state_in = emawa_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= emawa_pkg::BK_SWEEP;
         cnt_ff       <= '0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Word in work and response payload need no reset.
   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      rsp_average_ff <= rsp_average_in;
      rsp_flag_ff    <= rsp_flag_in;
   end

   assign sweeping_o    = (state_ff == emawa_pkg::BK_SWEEP);
   assign rsp_valid_o   = rsp_valid_ff;
   assign rsp_average_o = rsp_average_ff;
   assign rsp_flag_o    = rsp_flag_ff;

   // Nothing leaves the queue while the stores are being cleared.
   `EMAWA_ASSERT_SAME(a_no_pop_in_sweep, state_ff == emawa_pkg::BK_SWEEP, !pop_o, "pop during sweep")
   // A clear drops initialization and starts the sweep.
   `EMAWA_ASSERT_NEXT(a_clear_starts_sweep, pop_o && head_i.item.kind == emawa_pkg::OP_CLEAR, state_ff == emawa_pkg::BK_SWEEP && !init_ff, "clear did not start sweep")
   // The mix step always follows a lookup of an update.
   `EMAWA_ASSERT_SAME(a_mix_after_lookup, state_ff == emawa_pkg::BK_MIX, $past(state_ff) == emawa_pkg::BK_LOOKUP && item_ff.kind == emawa_pkg::OP_UPDATE, "mix without lookup")
   // A new response is only loaded from a read lookup.
   `EMAWA_ASSERT_SAME(a_rsp_from_read, rsp_valid_in && !rsp_valid_ff, state_ff == emawa_pkg::BK_LOOKUP && item_ff.kind == emawa_pkg::OP_READ, "response without read")

endmodule

`default_nettype wire

// File: sv/ema_weight_averager.sv
// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  tdata: entry_index, value_in; tuser: mode, region;
//                                             tlast: pass_last
// rsp_      out        rsp_tvalid/rsp_tready  tdata: average_out; tuser: ready_res
// csr_      in         csr_we                 csr_index selects the register, csr_wdata
//
// Each word waits in the queue, then the back part takes it: an ignored update or mode 3 is
// done in the idle state, a read or a first-pass copy also passes the lookup state, and a mixing
// update passes lookup and mix; the store's single registered read port and its later write set those steps.
// A clear holds the back part while both stores are swept one entry a cycle.
// After reset the same sweep runs and req_tready stays low until it ends.
// A stalled response holds the next read in its lookup state, and every word behind it waits.
`default_nettype none

module ema_weight_averager (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // [9:0] entry_index, [41:10] value_in, [47:42] zero
   input  wire logic [2:0]  req_tuser,   // [1:0] mode, [2] region
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] average_out
   output logic             rsp_tuser,   // [0] ready_res
   input  wire logic        csr_we,
   input  wire logic [emawa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [emawa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   emawa_pkg::item_type           front_item;
   emawa_pkg::q_head_type         q_head;
   logic [emawa_pkg::DECAY_W-1:0] decay;
   logic                          q_full;
   logic                          q_pop;
   logic                          sweeping;
   logic signed [emawa_pkg::FIELD_W-1:0] rsp_average;

   // Words enter only while the queue has room and no sweep runs.
   assign req_tready = !q_full && !sweeping;

   emawa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_mode   (req_tuser[1:0]),
      .req_region (req_tuser[2]),
      .req_index  (req_tdata[9:0]),
      .req_value  ($signed(req_tdata[41:10])),
      .req_last   (req_tlast),
      .item_o     (front_item),
      .decay_o    (decay)
   );

   emawa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (req_tvalid && req_tready),
      .item_i (front_item),
      .pop_i  (q_pop),
      .head_o (q_head),
      .full_o (q_full)
   );

   emawa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_i        (q_head),
      .decay_i       (decay),
      .pop_o         (q_pop),
      .sweeping_o    (sweeping),
      .rsp_ready_i   (rsp_tready),
      .rsp_valid_o   (rsp_tvalid),
      .rsp_average_o (rsp_average),
      .rsp_flag_o    (rsp_tuser)
   );

   assign rsp_tdata = rsp_average;

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam logic [emawa_pkg::MODE_W-1:0]      MODE_UNUSED  = 2'd3;
   localparam logic [emawa_pkg::CSR_INDEX_W-1:0] CSR_UNUSED   = 2'd3;
   localparam int                                LIMIT_CYCLES = 400000;
   // A clear or the reset sweep can keep the block busy this long with nothing to show.
   localparam int                                SETTLE_CYCLES = emawa_pkg::SWEEP_DEPTH + 64;
   localparam int                                PHASE_WORDS   = 108;

   typedef struct {
      logic signed [31:0] average;
      logic               ready;
   } average_word_type;

   typedef struct {
      int          send_idle;
      int          recv_idle;
      logic [15:0] decay;
      logic [15:0] wcount;
      logic [15:0] bcount;
   } phase_setting_type;

   // Shadow copy of both average stores; predicts every read and checks the responses.
   class average_tracker_type;
      logic signed [31:0] weight_avg [emawa_pkg::WEIGHT_DEPTH];
      bit                 weight_written [emawa_pkg::WEIGHT_DEPTH];
      logic signed [31:0] bias_avg [emawa_pkg::BIAS_DEPTH];
      bit                 bias_written [emawa_pkg::BIAS_DEPTH];
      bit                 initialized;
      logic [15:0]        decay;
      logic [10:0]        weight_count;
      logic [8:0]         bias_count;
      average_word_type   pending_reads[$];
      int                 mismatches;

      function new();
         foreach (weight_written[i]) weight_written[i] = 1'b0;
         foreach (bias_written[i]) bias_written[i] = 1'b0;
         initialized  = 1'b0;
         decay        = emawa_pkg::DECAY_RESET;
         weight_count = emawa_pkg::WCOUNT_RESET;
         bias_count   = emawa_pkg::BCOUNT_RESET;
         mismatches   = 0;
      endfunction

      function void apply_register(logic [emawa_pkg::CSR_INDEX_W-1:0] index, logic [15:0] data);
         case (index)
            emawa_pkg::CSR_DECAY:  decay = data;
            emawa_pkg::CSR_WCOUNT: weight_count = data[10:0];
            emawa_pkg::CSR_BCOUNT: bias_count = data[8:0];
            default: ;
         endcase
      endfunction

      function bit in_range(logic region, logic [9:0] idx);
         if (region == emawa_pkg::REGION_WEIGHT)
            return (idx < weight_count) && (idx < emawa_pkg::WEIGHT_DEPTH);
         return (idx < bias_count) && (idx < emawa_pkg::BIAS_DEPTH);
      endfunction

      // decay*avg + (1-decay)*value in Q0.16, rounded half up.
      function logic signed [31:0] mixed(logic signed [31:0] avg, logic signed [31:0] value);
         longint acc;
         acc = longint'(avg) * longint'(decay)
               + longint'(value) * longint'(emawa_pkg::DECAY_ONE - decay) + 64'sd32768;
         return 32'(acc >>> 16);
      endfunction

      function void note_word(logic [1:0] mode, logic region, logic [9:0] idx,
                              logic signed [31:0] value, logic last);
         logic signed [31:0] held;
         average_word_type   expected;
         bit                 hit;
         hit = in_range(region, idx);
         case (mode)
            emawa_pkg::MODE_UPDATE: begin
               if (hit && region == emawa_pkg::REGION_WEIGHT) begin
                  held = weight_written[idx] ? weight_avg[idx] : '0;
                  weight_avg[idx] = initialized ? mixed(held, value) : value;
                  weight_written[idx] = 1'b1;
               end else if (hit) begin
                  held = bias_written[idx] ? bias_avg[idx] : '0;
                  bias_avg[idx] = initialized ? mixed(held, value) : value;
                  bias_written[idx] = 1'b1;
               end
               // The pass ends even when its last word was out of range.
               if (last)
                  initialized = 1'b1;
            end
            emawa_pkg::MODE_READ: begin
               expected.average = '0;
               expected.ready   = hit && initialized;
               if (expected.ready) begin
                  if (region == emawa_pkg::REGION_WEIGHT && weight_written[idx])
                     expected.average = weight_avg[idx];
                  if (region == emawa_pkg::REGION_BIAS && bias_written[idx])
                     expected.average = bias_avg[idx];
               end
               pending_reads.push_back(expected);
            end
            emawa_pkg::MODE_CLEAR: begin
               foreach (weight_written[i]) weight_written[i] = 1'b0;
               foreach (bias_written[i]) bias_written[i] = 1'b0;
               initialized = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [31:0] average, logic ready);
         average_word_type expected;
         if (pending_reads.size() == 0) begin
            $error("unexpected response word: average_out %h, ready_res %b", average, ready);
            mismatches++;
            return;
         end
         expected = pending_reads.pop_front();
         if (average !== expected.average) begin
            $error("average_out: expected %h, got %h", expected.average, average);
            mismatches++;
         end
         if (ready !== expected.ready) begin
            $error("ready_res: expected %b, got %b", expected.ready, ready);
            mismatches++;
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [47:0]                       req_tdata;   // [9:0] entry_index, [41:10] value_in, [47:42] zero
   logic [2:0]                        req_tuser;   // [1:0] mode, [2] region
   logic                              req_tlast;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [31:0]                       rsp_tdata;   // [31:0] average_out
   logic                              rsp_tuser;   // [0] ready_res
   logic                              csr_we;
   logic [emawa_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [emawa_pkg::CSR_DATA_W-1:0]  csr_wdata;

   average_tracker_type tracker;
   int                  send_idle_pct = 32;
   int                  recv_idle_pct = 69;
   int                  words_sent = 0;
   int                  cycle_count = 0;

   // Entries that an accepted update has ever written; most reads target these.
   logic [9:0] touched_weights[$];
   logic [9:0] touched_biases[$];
   bit         weight_touched [emawa_pkg::WEIGHT_DEPTH];
   bit         bias_touched [emawa_pkg::BIAS_DEPTH];

   ema_weight_averager i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Response side: random back-pressure, every accepted word goes to the checker.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tdata, rsp_tuser);
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Present one request word with random gaps ahead of it and wait until it is taken.
   task automatic send_word(logic [1:0] mode, logic region, logic [9:0] idx,
                            logic [31:0] value, logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {6'b0, value, idx};
      req_tuser  = {region, mode};
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      if (mode == emawa_pkg::MODE_UPDATE && tracker.in_range(region, idx)) begin
         if (region == emawa_pkg::REGION_WEIGHT && !weight_touched[idx]) begin
            weight_touched[idx] = 1'b1;
            touched_weights.push_back(idx);
         end else if (region == emawa_pkg::REGION_BIAS && !bias_touched[idx]) begin
            bias_touched[idx] = 1'b1;
            touched_biases.push_back(idx);
         end
      end
      tracker.note_word(mode, region, idx, value, last);
      if (mode != MODE_UNUSED)
         words_sent++;
   endtask

   task automatic write_register(logic [emawa_pkg::CSR_INDEX_W-1:0] index, logic [15:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      tracker.apply_register(index, data);
   endtask

   // Stop sending, collect every outstanding response and let a clear sweep run out.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.pending_reads.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return 32'($urandom_range(262143)) - 32'd131072;
         default: return $urandom();
      endcase
   endfunction

   // Mostly low entries so that reads hit, some around the count, some anywhere and, for biases, some beyond the store.
   function automatic logic [9:0] pick_update_index(logic region);
      int count;
      count = region ? int'(tracker.bias_count) : int'(tracker.weight_count);
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return 10'($urandom_range(15));
         6, 7:             return 10'(count + int'($urandom_range(3)) - 2);
         8:                return 10'($urandom_range(1023));
         default:          return region ? 10'($urandom_range(1023, 256))
                                         : 10'($urandom_range(1023));
      endcase
   endfunction

   task automatic pick_read(output logic region, output logic [9:0] idx);
      region = 1'($urandom_range(1));
      if (region == emawa_pkg::REGION_WEIGHT && touched_weights.size() > 0
          && $urandom_range(5) != 0)
         idx = touched_weights[$urandom_range(touched_weights.size() - 1)];
      else if (region == emawa_pkg::REGION_BIAS && touched_biases.size() > 0
               && $urandom_range(5) != 0)
         idx = touched_biases[$urandom_range(touched_biases.size() - 1)];
      else begin
         // Beyond the bias store: no entry is touched.
         region = emawa_pkg::REGION_BIAS;
         idx = 10'($urandom_range(1023, emawa_pkg::BIAS_DEPTH));
      end
   endtask

   // One random sequence: mostly update passes and read bursts, some clears and noise.
   task automatic run_sequence();
      int         pick;
      int         len;
      logic       region;
      logic [9:0] idx;
      pick = $urandom_range(99);
      if (pick < 45) begin
         region = 1'($urandom_range(1));
         idx = pick_update_index(region);
         len = $urandom_range(8, 1);
         for (int k = 0; k < len; k++)
            send_word(emawa_pkg::MODE_UPDATE, region, idx + 10'(k), rand_value(),
                      (k == len - 1) && ($urandom_range(9) != 0));
      end else if (pick < 80) begin
         len = $urandom_range(6, 1);
         for (int k = 0; k < len; k++) begin
            pick_read(region, idx);
            send_word(emawa_pkg::MODE_READ, region, idx, $urandom(), 1'($urandom_range(1)));
         end
      end else if (pick < 83) begin
         send_word(emawa_pkg::MODE_CLEAR, 1'($urandom_range(1)), 10'($urandom_range(1023)),
                   $urandom(), 1'($urandom_range(1)));
      end else if (pick < 90) begin
         send_word(MODE_UNUSED, 1'($urandom_range(1)), 10'($urandom_range(1023)), $urandom(),
                   1'($urandom_range(1)));
      end else begin
         region = 1'($urandom_range(1));
         send_word(emawa_pkg::MODE_UPDATE, region, pick_update_index(region), rand_value(),
                   1'($urandom_range(1)));
      end
   endtask

   initial begin
      phase_setting_type phases[6];
      int                phase_start;
      tracker    = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      phases[0] = '{32, 69, 16'd65535, 16'd1024, 16'd256};
      phases[1] = '{32, 69, 16'd0,     16'd40,   16'd300};
      phases[2] = '{69, 32, 16'd32768, 16'd0,    16'd1};
      phases[3] = '{69, 32, 16'd1,     16'd1500, 16'd17};
      phases[4] = '{0,  0,  16'd65470, 16'd1023, 16'd255};
      phases[5] = '{0,  0,  16'd12345, 16'd600,  16'd0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset register values.
      // Read before initialization, beyond the bias store, and an unused mode.
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_BIAS, 10'd300, 32'hFFFF_FFFF, 1'b1);
      send_word(MODE_UNUSED, emawa_pkg::REGION_WEIGHT, 10'd0, 32'h5A5A_5A5A, 1'b1);
      // Copy pass with extreme values, ended by an out-of-range word.
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_WEIGHT, 10'd0, 32'h7FFF_FFFF, 1'b0);
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_WEIGHT, 10'd1023, 32'h8000_0000, 1'b0);
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_WEIGHT, 10'd5, 32'h0000_0000, 1'b0);
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_BIAS, 10'd0, 32'hFFFF_FFFF, 1'b0);
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_BIAS, 10'd255, 32'h1234_5678, 1'b0);
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_BIAS, 10'd300, 32'h0000_ABCD, 1'b1);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_WEIGHT, 10'd0, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_WEIGHT, 10'd1023, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_WEIGHT, 10'd5, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_BIAS, 10'd0, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_BIAS, 10'd255, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_BIAS, 10'd300, 32'h0, 1'b0);
      // Averaging across the full signed range.
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_WEIGHT, 10'd0, 32'h8000_0000, 1'b0);
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_WEIGHT, 10'd1023, 32'h7FFF_FFFF, 1'b0);
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_BIAS, 10'd0, 32'h0000_0001, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_WEIGHT, 10'd0, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_WEIGHT, 10'd1023, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_BIAS, 10'd0, 32'h0, 1'b0);
      // Clear, then an entry left out of the next copy pass reads as zero and averages from zero.
      send_word(emawa_pkg::MODE_CLEAR, emawa_pkg::REGION_BIAS, 10'd1023, 32'hFFFF_FFFF, 1'b1);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_WEIGHT, 10'd0, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_WEIGHT, 10'd5, 32'h0001_0000, 1'b1);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_WEIGHT, 10'd0, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_WEIGHT, 10'd5, 32'h0, 1'b0);
      send_word(emawa_pkg::MODE_UPDATE, emawa_pkg::REGION_WEIGHT, 10'd0, 32'h0002_0000, 1'b0);
      send_word(emawa_pkg::MODE_READ, emawa_pkg::REGION_WEIGHT, 10'd0, 32'h0, 1'b0);

      // Random part, one register setting per phase.
      for (int p = 0; p < 6; p++) begin
         drain();
         send_idle_pct = phases[p].send_idle;
         recv_idle_pct = phases[p].recv_idle;
         write_register(emawa_pkg::CSR_DECAY, phases[p].decay);
         write_register(emawa_pkg::CSR_WCOUNT, phases[p].wcount);
         write_register(emawa_pkg::CSR_BCOUNT, phases[p].bcount);
         if (p == 5)
            write_register(CSR_UNUSED, 16'hFFFF);
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS)
            run_sequence();
      end
      drain();

      if (tracker.mismatches == 0 && tracker.pending_reads.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/emawa_pkg.sv
sv/emawa_front.sv
sv/emawa_queue.sv
sv/emawa_back.sv
sv/ema_weight_averager.sv
verif/tb.sv
